FILE: design/blk3_pkg.sv
// Shared types, constants and helper functions of the single-chunk BLAKE3 hash unit.
// Used by every module in this folder; depends on nothing else.
package blk3_pkg;

    localparam int MAX_MESSAGE_BYTES = 1024;
    localparam int BLOCK_BYTES       = 64;
    localparam int HELD_W            = $clog2(BLOCK_BYTES + 1);
    localparam int TOTAL_W           = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int STEP_W            = 5;
    localparam int LAST_STEP         = 27;

    typedef logic [31:0] word_t;

    localparam word_t FLAG_CHUNK_START = 32'h0000_0001;
    localparam word_t FLAG_CHUNK_END   = 32'h0000_0002;
    localparam word_t FLAG_ROOT        = 32'h0000_0008;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  word_bytes;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
        logic        too_long;
    } out_item_t;

    // One compression request from the front to the back.
    typedef struct packed {
        logic [BLOCK_BYTES-1:0][7:0] block;
        logic [HELD_W-1:0]           len;
        logic                        start;
        logic                        is_final;
        logic                        ovf;
    } job_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_DONE
    } core_state_t;

    function automatic word_t iv_word(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            3'd7:    r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] msg_perm(input logic [3:0] idx);
        logic [3:0] r;
        case (idx)
            4'd0:    r = 4'd2;
            4'd1:    r = 4'd6;
            4'd2:    r = 4'd3;
            4'd3:    r = 4'd10;
            4'd4:    r = 4'd7;
            4'd5:    r = 4'd0;
            4'd6:    r = 4'd4;
            4'd7:    r = 4'd13;
            4'd8:    r = 4'd1;
            4'd9:    r = 4'd11;
            4'd10:   r = 4'd12;
            4'd11:   r = 4'd5;
            4'd12:   r = 4'd9;
            4'd13:   r = 4'd14;
            4'd14:   r = 4'd15;
            4'd15:   r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/blk3_jobq.sv
// Two-entry queue of compression jobs between the packing front and the compression core.
// Depends on blk3_pkg for the job type.
module blk3_jobq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  blk3_pkg::job_t  wr_job,
    output logic            q_full,
    input  logic            rd,
    output blk3_pkg::job_t  head,
    output logic            q_empty
);

    blk3_pkg::job_t slot_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_wr, do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign head    = slot_reg[rptr_reg];
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;

    always_comb
    begin
        wptr_next  = wptr_reg ^ do_wr;
        rptr_next  = rptr_reg ^ do_rd;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_job;
        end
    end

endmodule

FILE: design/blk3_front.sv
// Front end: accepts message words, packs their bytes into 64-byte blocks and issues jobs.
// Depends on blk3_pkg for types and limits.
module blk3_front (
    input  logic                clk,
    input  logic                rst_n,
    input  blk3_pkg::in_item_t  item,
    input  logic                push,
    output logic                full,
    output logic                job_wr,
    output blk3_pkg::job_t      job,
    input  logic                q_full
);

    logic [blk3_pkg::BLOCK_BYTES-1:0][7:0] buf_reg, buf_next;
    logic [blk3_pkg::HELD_W-1:0]           held_reg, held_next;
    logic [blk3_pkg::TOTAL_W-1:0]          total_reg, total_next;
    logic                                  cy_reg, cy_next;
    logic                                  ovf_reg, ovf_next;
    logic                                  pend_reg, pend_next;

    logic [blk3_pkg::BLOCK_BYTES-1:0][7:0] cur_buf, new_buf;
    logic [2:0]                            nb, n;
    logic [blk3_pkg::TOTAL_W-1:0]          avail;
    logic                                  drop, wrap, push_blk, fire;
    logic [blk3_pkg::HELD_W-1:0]           base, pos, new_held;
    logic [blk3_pkg::HELD_W:0]             sum;

    assign full = pend_reg || q_full;
    assign fire = push && !full;

    always_comb
    begin
        nb    = (item.word_bytes > 3'd4) ? 3'd4 : item.word_bytes;
        avail = blk3_pkg::TOTAL_W'(blk3_pkg::MAX_MESSAGE_BYTES) - total_reg;
        drop  = {{(blk3_pkg::TOTAL_W-3){1'b0}}, nb} > avail;
        n     = drop ? avail[2:0] : nb;
        // A full buffer is only compressed as a non-final block once another byte shows up.
        wrap  = (held_reg == blk3_pkg::HELD_W'(blk3_pkg::BLOCK_BYTES)) && (n != 3'd0);
        base  = wrap ? '0 : held_reg;
        sum   = {1'b0, held_reg} + {{(blk3_pkg::HELD_W-2){1'b0}}, n};
        push_blk = wrap || (sum > (blk3_pkg::HELD_W+1)'(blk3_pkg::BLOCK_BYTES));

        cur_buf = buf_reg;
        for (int i = 0; i < 4; i++)
        begin
            pos = base + blk3_pkg::HELD_W'(i);
            if ((3'(i) < n) && !wrap && !pos[blk3_pkg::HELD_W-1])
            begin
                cur_buf[pos[5:0]] = item.msg_word[8*i +: 8];
            end
        end
        new_buf = push_blk ? '0 : cur_buf;
        for (int i = 0; i < 4; i++)
        begin
            pos = base + blk3_pkg::HELD_W'(i);
            if ((3'(i) < n) && (wrap || pos[blk3_pkg::HELD_W-1]))
            begin
                new_buf[pos[5:0]] = item.msg_word[8*i +: 8];
            end
        end

        if (wrap)
        begin
            new_held = blk3_pkg::HELD_W'(n);
        end
        else if (push_blk)
        begin
            new_held = blk3_pkg::HELD_W'(sum - (blk3_pkg::HELD_W+1)'(blk3_pkg::BLOCK_BYTES));
        end
        else
        begin
            new_held = sum[blk3_pkg::HELD_W-1:0];
        end
    end

    always_comb
    begin
        buf_next   = buf_reg;
        held_next  = held_reg;
        total_next = total_reg;
        cy_next    = cy_reg;
        ovf_next   = ovf_reg;
        pend_next  = pend_reg;
        job_wr     = 1'b0;
        job        = '0;

        if (pend_reg)
        begin
            job.block    = buf_reg;
            job.len      = held_reg;
            job.start    = !cy_reg;
            job.is_final = 1'b1;
            job.ovf      = ovf_reg;
            if (!q_full)
            begin
                job_wr     = 1'b1;
                pend_next  = 1'b0;
                buf_next   = '0;
                held_next  = '0;
                total_next = '0;
                cy_next    = 1'b0;
                ovf_next   = 1'b0;
            end
        end
        else if (fire)
        begin
            if (push_blk)
            begin
                // Issue the filled block now; a final block stays in the buffer and is issued while pending.
                job_wr       = 1'b1;
                job.block    = cur_buf;
                job.len      = blk3_pkg::HELD_W'(blk3_pkg::BLOCK_BYTES);
                job.start    = !cy_reg;
                job.is_final = 1'b0;
                job.ovf      = 1'b0;
                buf_next     = new_buf;
                held_next    = new_held;
                total_next   = total_reg + blk3_pkg::TOTAL_W'(n);
                cy_next      = 1'b1;
                ovf_next     = ovf_reg || drop;
                pend_next    = item.last_word;
            end
            else if (item.last_word)
            begin
                job_wr       = 1'b1;
                job.block    = new_buf;
                job.len      = new_held;
                job.start    = !cy_reg;
                job.is_final = 1'b1;
                job.ovf      = ovf_reg || drop;
                buf_next     = '0;
                held_next    = '0;
                total_next   = '0;
                cy_next      = 1'b0;
                ovf_next     = 1'b0;
            end
            else
            begin
                buf_next   = new_buf;
                held_next  = new_held;
                total_next = total_reg + blk3_pkg::TOTAL_W'(n);
                ovf_next   = ovf_reg || drop;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            held_reg  <= '0;
            total_reg <= '0;
            cy_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            buf_reg   <= buf_next;
            held_reg  <= held_next;
            total_reg <= total_next;
            cy_reg    <= cy_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: design/blk3_core.sv
// Back end: iterative BLAKE3 compression, four half-G steps per round, and digest output.
// Depends on blk3_pkg for types, the IV and the message permutation.
module blk3_core (
    input  logic                clk,
    input  logic                rst_n,
    input  blk3_pkg::job_t      job,
    input  logic                q_empty,
    output logic                q_rd,
    output blk3_pkg::out_item_t result,
    output logic                empty,
    input  logic                pop
);

    blk3_pkg::core_state_t state_reg, state_next;

    blk3_pkg::word_t v_reg [16];
    blk3_pkg::word_t v_next [16];
    blk3_pkg::word_t w_reg [16];
    blk3_pkg::word_t w_next [16];
    blk3_pkg::word_t chain_reg [8];
    blk3_pkg::word_t h [8];
    logic [blk3_pkg::STEP_W-1:0] step_reg;
    logic                        fin_reg, ovf_reg;
    logic [3:0][63:0]            dig_reg;
    logic                        busy_reg, dig_ovf_reg;
    logic [1:0]                  part_reg;

    logic take, run, done, pop_ok;
    logic diag, second;
    blk3_pkg::word_t ga, gb, gc, gd, gx, a1, c1, dx, bx, d1, b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blk3_pkg::CORE_IDLE:
            begin
                if (!q_empty && (!job.is_final || !busy_reg))
                begin
                    state_next = blk3_pkg::CORE_RUN;
                end
            end
            blk3_pkg::CORE_RUN:
            begin
                if (step_reg == blk3_pkg::STEP_W'(blk3_pkg::LAST_STEP))
                begin
                    state_next = blk3_pkg::CORE_DONE;
                end
            end
            blk3_pkg::CORE_DONE:
            begin
                state_next = blk3_pkg::CORE_IDLE;
            end
            default:
            begin
                state_next = blk3_pkg::CORE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        take = 1'b0;
        run  = 1'b0;
        done = 1'b0;
        case (state_reg)
            blk3_pkg::CORE_IDLE: take = !q_empty && (!job.is_final || !busy_reg);
            blk3_pkg::CORE_RUN:  run  = 1'b1;
            blk3_pkg::CORE_DONE: done = 1'b1;
            default:             take = 1'b0;
        endcase
    end

    assign q_rd   = take;
    assign diag   = step_reg[1];
    assign second = step_reg[0];

    // Four G functions run side by side; diagonal steps rotate rows 1 to 3.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            v_next[i] = v_reg[i];
        end
        for (int j = 0; j < 4; j++)
        begin
            ga = v_reg[j];
            gb = diag ? v_reg[4 + ((j + 1) % 4)] : v_reg[4 + j];
            gc = diag ? v_reg[8 + ((j + 2) % 4)] : v_reg[8 + j];
            gd = diag ? v_reg[12 + ((j + 3) % 4)] : v_reg[12 + j];
            if (diag)
            begin
                gx = second ? w_reg[9 + 2*j] : w_reg[8 + 2*j];
            end
            else
            begin
                gx = second ? w_reg[1 + 2*j] : w_reg[2*j];
            end
            a1 = ga + gb + gx;
            dx = gd ^ a1;
            d1 = second ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
            c1 = gc + d1;
            bx = gb ^ c1;
            b1 = second ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
            v_next[j] = a1;
            if (diag)
            begin
                v_next[4 + ((j + 1) % 4)]  = b1;
                v_next[8 + ((j + 2) % 4)]  = c1;
                v_next[12 + ((j + 3) % 4)] = d1;
            end
            else
            begin
                v_next[4 + j]  = b1;
                v_next[8 + j]  = c1;
                v_next[12 + j] = d1;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[blk3_pkg::msg_perm(4'(i))];
        end
        for (int i = 0; i < 8; i++)
        begin
            h[i] = v_reg[i] ^ v_reg[i + 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blk3_pkg::CORE_IDLE;
            step_reg  <= '0;
            busy_reg  <= 1'b0;
            part_reg  <= 2'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= blk3_pkg::iv_word(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                step_reg <= '0;
            end
            else if (run)
            begin
                step_reg <= step_reg + blk3_pkg::STEP_W'(1);
            end
            if (done)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= fin_reg ? blk3_pkg::iv_word(3'(i)) : h[i];
                end
            end
            // A block of the next message may finish while a digest part is transferred.
            if (done && fin_reg)
            begin
                busy_reg <= 1'b1;
                part_reg <= 2'd0;
            end
            else if (pop_ok)
            begin
                part_reg <= part_reg + 2'd1;
                if (part_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i]     <= chain_reg[i];
                v_reg[i + 8] <= blk3_pkg::iv_word(3'(i));
            end
            v_reg[12] <= '0;
            v_reg[13] <= '0;
            v_reg[14] <= 32'(job.len);
            v_reg[15] <= (job.start ? blk3_pkg::FLAG_CHUNK_START : '0)
                       | (job.is_final ? (blk3_pkg::FLAG_CHUNK_END | blk3_pkg::FLAG_ROOT) : '0);
            for (int k = 0; k < 16; k++)
            begin
                w_reg[k] <= blk3_pkg::word_t'(job.block[4*k +: 4]);
            end
            fin_reg <= job.is_final;
            ovf_reg <= job.ovf;
        end
        else if (run)
        begin
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i] <= v_next[i];
            end
            if (step_reg[1:0] == 2'd3)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    w_reg[i] <= w_next[i];
                end
            end
        end
        if (done && fin_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                dig_reg[k] <= {h[2*k + 1], h[2*k]};
            end
            dig_ovf_reg <= ovf_reg;
        end
    end

    assign empty  = !busy_reg;
    assign pop_ok = pop && busy_reg;

    always_comb
    begin
        result.digest_part = dig_reg[part_reg];
        result.part_index  = part_reg;
        result.last_part   = (part_reg == 2'd3);
        result.too_long    = dig_ovf_reg;
    end

endmodule

FILE: design/blake3_single_chunk_hash_unit.sv
// Top level of the single-chunk BLAKE3 hash unit: front packer, job queue, compression core.
// Depends on blk3_pkg, blk3_front, blk3_jobq and blk3_core.
//
// Usage: the message enters as a stream of little-endian words on item, one transfer per
// cycle while full is low (push high). word_bytes gives the valid bytes, last_word ends the
// message. Bytes beyond 1024 are dropped and too_long is set on the digest.
// The front takes one word per cycle until the two-entry job queue is full; a word that
// completes a block and also ends the message holds the front until its final block is issued.
// Each compression in the core loads the state, runs 28 half-G steps (four G
// units side by side, seven rounds) and then folds the state into the chain value.
// The 32-byte digest leaves as four transfers on result, part 0 first, while empty is low.
// If the receiver stalls, the digest is held; the core keeps compressing blocks of the next
// message but does not start its final block until all four parts have been popped.
// Reset clears all control state and loads the chain value with the IV; the unit is ready
// for a new message in the cycle after reset is released, and after each digest.
module blake3_single_chunk_hash_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blk3_pkg::in_item_t   item,
    input  logic                 push,
    output logic                 full,
    output blk3_pkg::out_item_t  result,
    output logic                 empty,
    input  logic                 pop
);

    blk3_pkg::job_t wr_job, head;
    logic           job_wr, q_full, q_empty, q_rd;

    blk3_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .job_wr (job_wr),
        .job    (wr_job),
        .q_full (q_full)
    );

    blk3_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_wr),
        .wr_job  (wr_job),
        .q_full  (q_full),
        .rd      (q_rd),
        .head    (head),
        .q_empty (q_empty)
    );

    blk3_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (head),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_wr |-> !q_full)
        else $error("job issued into a full queue");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> !q_empty)
        else $error("core took a job from an empty queue");

    a_last_part_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && result.last_part) |=> empty)
        else $error("digest still shown after its last part was transferred");

    a_part_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last_part) |=>
            (!empty && result.part_index == $past(result.part_index) + 2'd1))
        else $error("digest part order broken");

endmodule
